// ===== hdl/assert_macros.svh =====
// Assertion helpers. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smf_pkg.sv =====
package smf_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN  = 2'd2;

    localparam logic REC_MATCH = 1'b0;
    localparam logic REC_END   = 1'b1;

    typedef struct packed {
        logic hit;
        logic last;
        logic any_found;
    } smf_flags_t;

endpackage

// ===== hdl/smf_front.sv =====
module smf_front #(
    parameter int MAX_PATTERN   = smf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [smf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [smf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                in_last,
    output logic                                push,
    output smf_pkg::smf_flags_t                 push_flags,
    output logic [POSITION_BITS-1:0]            push_pos,
    input  logic                                queue_full
);
    import smf_pkg::*;

    localparam int LW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SW = POSITION_BITS + 1;
    localparam logic [SW-1:0] POS_MAX  = {1'b0, {POSITION_BITS{1'b1}}};
    localparam logic [SW-1:0] SEEN_MAX = POS_MAX + SW'(MAX_PATTERN);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    logic [7:0]    win_reg  [MAX_PATTERN];
    logic [7:0]    win_next [MAX_PATTERN];
    logic [7:0]    pat      [MAX_PATTERN];
    logic [SW-1:0] seen_reg, seen_next, seen_inc;
    logic          found_reg, found_next;

    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [LW:0]             len_act;
    logic [LW-1:0]           len_m1;
    logic [MAX_PATTERN-1:0]  lane_ok;
    logic [SW-1:0]           pos_full;
    logic                    hit;
    logic                    accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // length clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (pat_len_reg == '0)
            len_act = (LW+1)'(1);
        else if (pat_len_reg > LEN_W'(MAX_PATTERN))
            len_act = (LW+1)'(MAX_PATTERN);
        else
            len_act = pat_len_reg[LW:0];
        len_m1 = LW'(len_act - (LW+1)'(1));
    end

    assign pat_all = {pat_high_reg, pat_low_reg};

    // lane j holds the byte j places back; it must equal pattern byte len-1-j
    assign win_next[0] = in_byte;
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_lane
        logic [LW-1:0] sel;
        assign pat[j] = pat_all[8*j +: 8];
        if (j > 0)
        begin : g_shift
            assign win_next[j] = win_reg[j-1];
        end
        assign sel        = len_m1 - LW'(j);
        assign lane_ok[j] = (LW'(j) > len_m1) || (win_next[j] == pat[sel]);
    end

    assign seen_inc = (seen_reg < SEEN_MAX) ? seen_reg + SW'(1) : seen_reg;
    assign hit      = (&lane_ok) && (seen_inc >= SW'(len_act));
    assign pos_full = seen_inc - SW'(len_act);
    assign push_pos = (pos_full > POS_MAX) ? {POSITION_BITS{1'b1}}
                                           : pos_full[POSITION_BITS-1:0];

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (hit || in_last);

    assign push_flags.hit       = hit;
    assign push_flags.last      = in_last;
    assign push_flags.any_found = found_reg || hit;

    always_comb
    begin
        seen_next  = seen_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (in_last)
            begin
                seen_next  = '0;
                found_next = 1'b0;
            end
            else
            begin
                seen_next  = seen_inc;
                found_next = found_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            found_reg <= found_next;
        end
    end

    // window contents only matter once seen covers the pattern, so no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

// ===== hdl/smf_queue.sv =====
module smf_queue #(
    parameter int WIDTH = smf_pkg::POSITION_BITS_DEF + 3,
    parameter int DEPTH = smf_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hdl/smf_back.sv =====
module smf_back #(
    parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     empty,
    output logic                     pop,
    input  smf_pkg::smf_flags_t      pop_flags,
    input  logic [POSITION_BITS-1:0] pop_pos,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_kind,
    output logic [POSITION_BITS-1:0] out_pos,
    output logic                     out_any,
    output logic                     out_last
);
    import smf_pkg::*;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_kind_reg, out_kind_next;
    logic [POSITION_BITS-1:0] out_pos_reg, out_pos_next;
    logic                     out_any_reg, out_any_next;
    logic                     out_last_reg, out_last_next;
    logic                     pend_end_reg, pend_end_next;
    logic                     pend_any_reg, pend_any_next;
    logic                     out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = out_free && !pend_end_reg && !empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_pos_next   = out_pos_reg;
        out_any_next   = out_any_reg;
        out_last_next  = out_last_reg;
        pend_end_next  = pend_end_reg;
        pend_any_next  = pend_any_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (pend_end_reg)
            begin
                // end record owed by a match on the final byte
                out_valid_next = 1'b1;
                out_kind_next  = REC_END;
                out_pos_next   = '0;
                out_any_next   = pend_any_reg;
                out_last_next  = 1'b1;
                pend_end_next  = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next = 1'b1;
                if (pop_flags.hit)
                begin
                    out_kind_next = REC_MATCH;
                    out_pos_next  = pop_pos;
                    out_any_next  = 1'b0;
                    out_last_next = !pop_flags.last;
                    pend_end_next = pop_flags.last;
                    pend_any_next = pop_flags.any_found;
                end
                else
                begin
                    out_kind_next = REC_END;
                    out_pos_next  = '0;
                    out_any_next  = pop_flags.any_found;
                    out_last_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_end_reg  <= pend_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_pos_reg  <= out_pos_next;
        out_any_reg  <= out_any_next;
        out_last_reg <= out_last_next;
        pend_any_reg <= pend_any_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_pos   = out_pos_reg;
    assign out_any   = out_any_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/substring_match_finder.sv =====
// channel   | direction | signals                         | content
// s_axis    | in        | tvalid tready tdata tlast       | text byte, final-byte mark
// m_axis    | out       | tvalid tready tdata tuser tlast | match / end records
// cfg       | in        | cfg_valid cfg_ready cfg_addr/data | pattern registers
//
// One text byte per cycle while the queue is not full; window compare and position count
// are combinational ahead of a 4-entry queue, and the output register follows the queue.
// A match on the final byte makes two records; no pop until the end record is loaded.
// Reset (rst_n, async low) clears counts, flags and queue; pattern length resets to 1.
// s_axis_tready drops only when the queue is full; cfg_ready is always high.
module substring_match_finder #(
    parameter int MAX_PATTERN   = smf_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF,
    parameter int TDATA_W       = ((POSITION_BITS + 8) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [smf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // text_byte
    input  logic                               s_axis_tlast,  // last_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [TDATA_W-1:0]                 m_axis_tdata,  // match_position, any_found
    output logic                               m_axis_tuser,  // record_kind
    output logic                               m_axis_tlast   // last_result
);
    import smf_pkg::*;

    localparam int QW = $bits(smf_flags_t) + POSITION_BITS;

    logic                     push, pop, q_full, q_empty;
    smf_flags_t               push_flags, pop_flags;
    logic [POSITION_BITS-1:0] push_pos, pop_pos;
    logic [QW-1:0]            q_pop_data;
    logic [POSITION_BITS-1:0] out_pos;
    logic                     out_any;

    assign cfg_ready = 1'b1;

    smf_front #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_flags (push_flags),
        .push_pos   (push_pos),
        .queue_full (q_full)
    );

    smf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_pos}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    assign pop_flags = smf_flags_t'(q_pop_data[QW-1:POSITION_BITS]);
    assign pop_pos   = q_pop_data[POSITION_BITS-1:0];

    smf_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop       (pop),
        .pop_flags (pop_flags),
        .pop_pos   (pop_pos),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_pos   (out_pos),
        .out_any   (out_any),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'({out_any, out_pos});

endmodule

// ===== hdl/smf_checker.sv =====
`include "assert_macros.svh"

module smf_checker #(
    parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF,
    parameter int TDATA_W       = ((POSITION_BITS + 8) / 8) * 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);
    import smf_pkg::*;

    `SMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed while stalled")

    `SMF_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser == REC_END, m_axis_tlast, "end record without tlast")

    `SMF_ASSERT_NOW(a_end_pos_zero, m_axis_tvalid && m_axis_tuser == REC_END, m_axis_tdata[POSITION_BITS-1:0] == '0, "end record carries a position")

    `SMF_ASSERT_NOW(a_match_no_flag, m_axis_tvalid && m_axis_tuser == REC_MATCH, !m_axis_tdata[POSITION_BITS], "match record sets any_found")

    `SMF_ASSERT_NEXT(a_end_follows, m_axis_tvalid && m_axis_tready && m_axis_tuser == REC_MATCH && !m_axis_tlast, m_axis_tvalid && m_axis_tuser == REC_END, "end record did not follow final match")

endmodule

bind substring_match_finder smf_checker #(
    .POSITION_BITS (POSITION_BITS),
    .TDATA_W       (TDATA_W)
) u_smf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
